/* src/wsd_pkg.sv */
// ----------------------------------------------------------------------------
// wsd_pkg: shared types and constants for the WebSocket frame deframer
// Parse phase encoding, length codes and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

	// 7-bit length codes that announce an extended length
	localparam logic [6:0] LEN16_CODE = 7'd126;
	localparam logic [6:0] LEN64_CODE = 7'd127;

	// extended length byte counts, as seen by the 3-bit byte counter
	// (eight bytes wrap the counter back to zero)
	localparam logic [2:0] EXT16_BYTES = 3'd2;
	localparam logic [2:0] EXT64_BYTES = 3'd0;
	localparam logic [2:0] KEY_BYTES   = 3'd4;

	localparam int unsigned LEN_W = 63;

	typedef enum logic [4:0] {
		PH_B0  = 5'b00001,
		PH_B1  = 5'b00010,
		PH_EXT = 5'b00100,
		PH_KEY = 5'b01000,
		PH_PAY = 5'b10000
	} phase_t;

	typedef enum logic {
		KIND_HEADER  = 1'b0,
		KIND_PAYLOAD = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic              fin;
		logic [2:0]        rsv;
		logic [3:0]        opcode;
		logic              masked;
		logic [LEN_W-1:0]  length;
		logic [7:0]        data;
		logic              last;
	} res_t;

endpackage

`default_nettype wire

/* src/websocket_frame_deframer.sv */
// Path: an accepted byte's result passes through the input register, then the
// result register, before it reaches the outputs.
// Throughput: one byte per cycle, limited only by output back-pressure.
// Header and key bytes produce no item, except the byte that completes the header.
// Reset: arst_n clears the parse state to the first header byte and empties
// both registers.
// ----------------------------------------------------------------------------
// websocket_frame_deframer: RFC 6455 frame parser, one byte per item
// Emits one header item per frame and one unmasked item per payload byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_deframer
	import wsd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// byte stream in
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        in_byte,
	// parsed items out
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   result_kind,
	output logic                   fin_bit,
	output logic [2:0]             reserved_bits,
	output logic [3:0]             frame_opcode,
	output logic                   is_masked,
	output logic [LEN_W-1:0]       payload_length,
	output logic [7:0]             data_byte,
	output logic                   last_of_frame
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// result register
	logic       out_valid_q;
	res_t       res_q;

	logic       go_s1;
	logic       emit;
	res_t       res;

	// the stage-1 byte retires when the result register has room; bytes that
	// produce no item retire too, so header bytes that emit nothing never wait on the sink
	assign go_s1    = valid_s1 && (!emit || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

	wsd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (go_s1),
		.in_byte (byte_s1),
		.emit    (emit),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && emit) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_kind    = res_q.kind;
	assign fin_bit        = res_q.fin;
	assign reserved_bits  = res_q.rsv;
	assign frame_opcode   = res_q.opcode;
	assign is_masked      = res_q.masked;
	assign payload_length = res_q.length;
	assign data_byte      = res_q.data;
	assign last_of_frame  = res_q.last;

endmodule

`default_nettype wire

/* src/wsd_parser.sv */
// ----------------------------------------------------------------------------
// wsd_parser: frame header parser and payload unmasker
// Holds the frame state; one byte is consumed per step strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsd_parser
	import wsd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] in_byte,
	output logic            emit,
	output res_t            res
);

	phase_t            phase_q, phase_n;
	logic [15:0]       hdr_q, hdr_n;
	logic [2:0]        cnt_q, cnt_n;
	logic [63:0]       len_q, len_n;
	logic [31:0]       key_q, key_n;
	logic [LEN_W-1:0]  rem_q, rem_n;
	logic [1:0]        kidx_q, kidx_n;

	logic              fin_hdr;
	logic [LEN_W-1:0]  fin_len;
	logic [2:0]        cnt_inc;
	logic [2:0]        ext_need;
	logic [63:0]       len_shift;
	logic [7:0]        key_byte;
	logic              pay_last;

	assign cnt_inc   = cnt_q + 3'd1;
	assign ext_need  = (hdr_q[6:0] == LEN16_CODE) ? EXT16_BYTES : EXT64_BYTES;
	assign len_shift = {len_q[55:0], in_byte};
	assign pay_last  = (rem_q == {{(LEN_W-1){1'b0}}, 1'b1});

	always_comb begin
		unique case (kidx_q)
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			2'd3: key_byte = key_q[7:0];
			default: key_byte = key_q[31:24];
		endcase
	end

	always_comb begin
		phase_n = phase_q;
		hdr_n   = hdr_q;
		cnt_n   = cnt_q;
		len_n   = len_q;
		key_n   = key_q;
		rem_n   = rem_q;
		kidx_n  = kidx_q;
		fin_hdr = 1'b0;
		fin_len = len_q[LEN_W-1:0];
		emit    = 1'b0;
		res     = '{kind: KIND_PAYLOAD, fin: hdr_q[15], rsv: hdr_q[14:12],
			opcode: hdr_q[11:8], masked: hdr_q[7], length: len_q[LEN_W-1:0],
			data: in_byte ^ key_byte, last: pay_last};

		unique case (phase_q)
			PH_B1: begin
				hdr_n = {hdr_q[15:8], in_byte};
				len_n = '0;
				key_n = '0;
				cnt_n = '0;
				if (in_byte[6:0] == LEN16_CODE || in_byte[6:0] == LEN64_CODE) begin
					phase_n = PH_EXT;
				end else if (in_byte[7]) begin
					len_n   = {57'd0, in_byte[6:0]};
					phase_n = PH_KEY;
				end else begin
					fin_hdr = 1'b1;
					fin_len = {{(LEN_W-7){1'b0}}, in_byte[6:0]};
				end
			end
			PH_EXT: begin
				len_n = len_shift;
				cnt_n = cnt_inc;
				if (cnt_inc == ext_need) begin
					cnt_n = '0;
					if (hdr_q[7]) begin
						phase_n = PH_KEY;
					end else begin
						fin_hdr = 1'b1;
						fin_len = len_shift[LEN_W-1:0];
					end
				end
			end
			PH_KEY: begin
				key_n = {key_q[23:0], in_byte};
				cnt_n = cnt_inc;
				if (cnt_inc == KEY_BYTES) begin
					fin_hdr = 1'b1;
				end
			end
			PH_PAY: begin
				emit   = 1'b1;
				kidx_n = kidx_q + 2'd1;
				rem_n  = rem_q - {{(LEN_W-1){1'b0}}, 1'b1};
				if (pay_last) begin
					phase_n = PH_B0;
				end
			end
			default: begin
				hdr_n   = {in_byte, 8'h00};
				phase_n = PH_B1;
			end
		endcase

		// header complete: latch the length and emit the header item
		if (fin_hdr) begin
			len_n   = {1'b0, fin_len};
			rem_n   = fin_len;
			kidx_n  = '0;
			cnt_n   = '0;
			emit    = 1'b1;
			phase_n = (fin_len == '0) ? PH_B0 : PH_PAY;
			res     = '{kind: KIND_HEADER, fin: hdr_n[15], rsv: hdr_n[14:12],
				opcode: hdr_n[11:8], masked: hdr_n[7], length: fin_len,
				data: 8'h00, last: (fin_len == '0)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_B0;
			hdr_q   <= '0;
			cnt_q   <= '0;
			len_q   <= '0;
			key_q   <= '0;
			rem_q   <= '0;
			kidx_q  <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			hdr_q   <= hdr_n;
			cnt_q   <= cnt_n;
			len_q   <= len_n;
			key_q   <= key_n;
			rem_q   <= rem_n;
			kidx_q  <= kidx_n;
		end
	end

endmodule

`default_nettype wire

/* src/wsd_checker.sv */
// ----------------------------------------------------------------------------
// wsd_checker: port-level checks for the frame deframer
// Input and output hold under stall and header/payload consistency of items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsd_checker
	import wsd_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic [7:0]       in_byte,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic             result_kind,
	input wire logic             fin_bit,
	input wire logic [2:0]       reserved_bits,
	input wire logic [3:0]       frame_opcode,
	input wire logic             is_masked,
	input wire logic [LEN_W-1:0] payload_length,
	input wire logic [7:0]       data_byte,
	input wire logic             last_of_frame
);

	// a waiting input byte holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_byte))
		else $error("input item changed while waiting");

	// a stalled item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_byte)
			&& $stable(payload_length) && $stable(last_of_frame)
			&& $stable(result_kind) && $stable(fin_bit)
			&& $stable(reserved_bits) && $stable(frame_opcode)
			&& $stable(is_masked))
		else $error("output item changed while stalled");

	// an empty frame ends on its header item
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_HEADER && payload_length == '0
			|-> last_of_frame)
		else $error("empty frame header not marked last");

	// a frame with payload does not end on its header
	a_hdr_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_HEADER && payload_length != '0
			|-> !last_of_frame)
		else $error("non-empty frame header marked last");

	// payload bytes only belong to frames with a nonzero length
	a_pay_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_PAYLOAD |-> payload_length != '0)
		else $error("payload item in an empty frame");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.in_byte        (in_byte),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.result_kind    (result_kind),
	.fin_bit        (fin_bit),
	.reserved_bits  (reserved_bits),
	.frame_opcode   (frame_opcode),
	.is_masked      (is_masked),
	.payload_length (payload_length),
	.data_byte      (data_byte),
	.last_of_frame  (last_of_frame)
);

`default_nettype wire
